// ===== sv/sbps_pkg.sv =====
package sbps_pkg;

   // Fixed field widths of the vertex stream and of the results
   localparam int FIELD_BITS  = 16;
   localparam int COLOR_BITS  = 24;
   localparam int ENERGY_BITS = 34;
   localparam int PROD_BITS   = 32;
   localparam int OUT_TOTAL_BITS = 48;
   localparam int NUM_CORNERS = 3;

   // Result index codes
   localparam logic [1:0] CORNER_FIRST = 2'd0;
   localparam logic [1:0] CORNER_MID   = 2'd1;
   localparam logic [1:0] CORNER_LAST  = 2'd2;

   // Position of a vertex within its strip
   typedef enum logic [1:0] {
      POS_FIRST,
      POS_SECOND,
      POS_EVEN,
      POS_ODD
   } vpos_type;

   // One vertex request
   typedef struct packed {
      logic signed [FIELD_BITS-1:0] vert_x;
      logic signed [FIELD_BITS-1:0] vert_y;
      logic signed [FIELD_BITS-1:0] vert_z;
      logic [FIELD_BITS-1:0]        unshot_red;
      logic [FIELD_BITS-1:0]        unshot_green;
      logic [FIELD_BITS-1:0]        unshot_blue;
      logic [FIELD_BITS-1:0]        patch_area;
      logic [COLOR_BITS-1:0]        patch_color;
      logic                         strip_begin;
      logic                         strip_end;
      logic                         scene_begin;
   } req_type;

   // One result
   typedef struct packed {
      logic [1:0]                   corner;
      logic signed [FIELD_BITS-1:0] corner_x;
      logic signed [FIELD_BITS-1:0] corner_y;
      logic signed [FIELD_BITS-1:0] corner_z;
      logic [ENERGY_BITS-1:0]       best_energy;
      logic [FIELD_BITS-1:0]        best_area;
      logic [COLOR_BITS-1:0]        best_color;
      logic [OUT_TOTAL_BITS-1:0]    total_red;
      logic [OUT_TOTAL_BITS-1:0]    total_green;
      logic [OUT_TOTAL_BITS-1:0]    total_blue;
      logic [OUT_TOTAL_BITS-1:0]    total_all;
      logic                         final_corner;
   } rsp_type;

   // Corner in output form
   typedef struct packed {
      logic [FIELD_BITS-1:0] x;
      logic [FIELD_BITS-1:0] y;
      logic [FIELD_BITS-1:0] z;
   } corner_type;

   // Strip-end snapshot handed to the result sequencer
   typedef struct packed {
      corner_type [NUM_CORNERS-1:0] corners;
      logic [ENERGY_BITS-1:0]       best_energy;
      logic [FIELD_BITS-1:0]        best_area;
      logic [COLOR_BITS-1:0]        best_color;
      logic [OUT_TOTAL_BITS-1:0]    total_red;
      logic [OUT_TOTAL_BITS-1:0]    total_green;
      logic [OUT_TOTAL_BITS-1:0]    total_blue;
      logic [OUT_TOTAL_BITS-1:0]    total_all;
   } snap_type;

   // Sequencer status back to the update stage
   typedef struct packed {
      logic busy;
      logic last_take;
   } emit_status_type;

endpackage

// ===== sv/sbps_req_if.sv =====
interface sbps_req_if import sbps_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sbps_rsp_if.sv =====
interface sbps_rsp_if import sbps_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sbps_emit.sv =====
module sbps_emit import sbps_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  snap_type        snap,
   output emit_status_type status,
   sbps_rsp_if.source      rsp_chan
);

   logic       busy_ff, busy_in;
   logic [1:0] cnt_ff, cnt_in;
   snap_type   snap_ff;
   logic       take;
   corner_type sel;

   assign take = rsp_chan.valid && rsp_chan.ready;
   assign status.busy = busy_ff;
   assign status.last_take = take && (cnt_ff == CORNER_LAST);

   // result counter and busy flag
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = CORNER_FIRST;
      end else if (status.last_take) begin
         busy_in = 1'b0;
      end else if (take) begin
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= CORNER_FIRST;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // snapshot holds until the last result of the strip is taken
   always_ff @(posedge clock) begin
      if (load) begin
         snap_ff <= snap;
      end
   end

   // corner select
   always_comb begin
      case (cnt_ff)
         CORNER_FIRST: sel = snap_ff.corners[0];
         CORNER_MID:   sel = snap_ff.corners[1];
         CORNER_LAST:  sel = snap_ff.corners[2];
         default:      sel = snap_ff.corners[0];
      endcase
   end

   assign rsp_chan.valid = busy_ff;
   always_comb begin
      rsp_chan.data.corner       = cnt_ff;
      rsp_chan.data.corner_x     = sel.x;
      rsp_chan.data.corner_y     = sel.y;
      rsp_chan.data.corner_z     = sel.z;
      rsp_chan.data.best_energy  = snap_ff.best_energy;
      rsp_chan.data.best_area    = snap_ff.best_area;
      rsp_chan.data.best_color   = snap_ff.best_color;
      rsp_chan.data.total_red    = snap_ff.total_red;
      rsp_chan.data.total_green  = snap_ff.total_green;
      rsp_chan.data.total_blue   = snap_ff.total_blue;
      rsp_chan.data.total_all    = snap_ff.total_all;
      rsp_chan.data.final_corner = (cnt_ff == CORNER_LAST);
   end

   // counter stays within the three corners
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != 2'd3))
      else $error("result counter out of range");

   // a taken non-final result advances the counter
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (take && !status.last_take && !load) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("result counter did not advance");

   // the final result ends the burst unless a new snapshot came in
   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      (status.last_take && !load) |=> !busy_ff)
      else $error("sequencer still busy after final result");

endmodule

// ===== sv/strip_brightest_patch_select.sv =====
// Timing: a vertex request is registered at acceptance and updates the totals and the
//   best patch as it leaves the input register; a strip end loads the sequencer's
//   snapshot, its first result is then valid, the other two follow one per taken cycle.
// Throughput: one vertex per cycle; a strip end yields three results, and a second strip
//   end waits in the input register until the final result of the previous one is taken.
// Reset: synchronous, active high; clears the strip position, vertices, totals, best patch.
module strip_brightest_patch_select import sbps_pkg::*; #(
   parameter int COORD_BITS = 16,
   parameter int TOTAL_BITS = 48
) (
   input  logic       clock,
   input  logic       reset,
   sbps_req_if.sink   req_chan,
   sbps_rsp_if.source rsp_chan
);

   localparam int EXT_BITS = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
   } vtx_type;

   // input register
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   logic    s1_adv, accept;

   // strip and scene state
   vpos_type              pos_ff, pos_in, pos_base;
   vtx_type               prev0_ff, prev1_ff;
   logic [TOTAL_BITS-1:0] tot_r_ff, tot_g_ff, tot_b_ff, tot_all_ff;
   logic [TOTAL_BITS-1:0] tot_r_in, tot_g_in, tot_b_in, tot_all_in;
   logic [TOTAL_BITS-1:0] tot_r_base, tot_g_base, tot_b_base, tot_all_base;
   logic [ENERGY_BITS-1:0] best_energy_ff, best_energy_in, energy_base;
   logic [FIELD_BITS-1:0]  best_area_ff;
   logic [COLOR_BITS-1:0]  best_color_ff;
   vtx_type                best_c0_ff, best_c1_ff, best_c2_ff;
   vtx_type                best_c0_in, best_c1_in, best_c2_in;

   logic signed [EXT_BITS-1:0] ext_x, ext_y, ext_z;
   vtx_type                cur;
   logic                   closes, better;
   logic [PROD_BITS-1:0]   prod_r, prod_g, prod_b;
   logic [ENERGY_BITS-1:0] energy;

   emit_status_type emit_st;
   snap_type        snap;
   logic            snap_load;

   function automatic logic [TOTAL_BITS-1:0] sat_add(input logic [TOTAL_BITS-1:0] a,
                                                     input logic [ENERGY_BITS-1:0] b);
      logic [TOTAL_BITS:0] sum;
      sum = {1'b0, a} + (TOTAL_BITS + 1)'(b);
      if (sum[TOTAL_BITS]) begin
         return '1;
      end
      return sum[TOTAL_BITS-1:0];
   endfunction

   function automatic corner_type to_corner(input vtx_type v);
      corner_type c;
      c.x = FIELD_BITS'(v.x);
      c.y = FIELD_BITS'(v.y);
      c.z = FIELD_BITS'(v.z);
      return c;
   endfunction

   // a strip end holds in the input register while the sequencer is mid-burst
   assign s1_adv = s1_valid_ff && !(s1_ff.strip_end && emit_st.busy && !emit_st.last_take);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_chan.data;
      end
   end

   // vertex coordinates in storage width
   always_comb begin
      ext_x = EXT_BITS'(s1_ff.vert_x);
      ext_y = EXT_BITS'(s1_ff.vert_y);
      ext_z = EXT_BITS'(s1_ff.vert_z);
      cur.x = ext_x[COORD_BITS-1:0];
      cur.y = ext_y[COORD_BITS-1:0];
      cur.z = ext_z[COORD_BITS-1:0];
   end

   // scene clear and strip restart come first
   always_comb begin
      tot_r_base   = s1_ff.scene_begin ? '0 : tot_r_ff;
      tot_g_base   = s1_ff.scene_begin ? '0 : tot_g_ff;
      tot_b_base   = s1_ff.scene_begin ? '0 : tot_b_ff;
      tot_all_base = s1_ff.scene_begin ? '0 : tot_all_ff;
      energy_base  = s1_ff.scene_begin ? '0 : best_energy_ff;
      pos_base     = s1_ff.strip_begin ? POS_FIRST : pos_ff;
      closes       = (pos_base == POS_EVEN) || (pos_base == POS_ODD);
   end

   // patch energy and running totals
   always_comb begin
      prod_r = PROD_BITS'(s1_ff.unshot_red) * PROD_BITS'(s1_ff.patch_area);
      prod_g = PROD_BITS'(s1_ff.unshot_green) * PROD_BITS'(s1_ff.patch_area);
      prod_b = PROD_BITS'(s1_ff.unshot_blue) * PROD_BITS'(s1_ff.patch_area);
      energy = ENERGY_BITS'(prod_r) + ENERGY_BITS'(prod_g) + ENERGY_BITS'(prod_b);
      if (closes) begin
         tot_r_in   = sat_add(tot_r_base, ENERGY_BITS'(prod_r));
         tot_g_in   = sat_add(tot_g_base, ENERGY_BITS'(prod_g));
         tot_b_in   = sat_add(tot_b_base, ENERGY_BITS'(prod_b));
         tot_all_in = sat_add(tot_all_base, energy);
      end else begin
         tot_r_in   = tot_r_base;
         tot_g_in   = tot_g_base;
         tot_b_in   = tot_b_base;
         tot_all_in = tot_all_base;
      end
      better = closes && (energy > energy_base);
   end

   // best patch; odd triangles swap corners 1 and 2
   always_comb begin
      best_energy_in = energy_base;
      best_c0_in     = best_c0_ff;
      best_c1_in     = best_c1_ff;
      best_c2_in     = best_c2_ff;
      if (better) begin
         best_energy_in = energy;
         best_c0_in     = prev0_ff;
         if (pos_base == POS_EVEN) begin
            best_c1_in = prev1_ff;
            best_c2_in = cur;
         end else begin
            best_c1_in = cur;
            best_c2_in = prev1_ff;
         end
      end
   end

   // next strip position
   always_comb begin
      if (s1_ff.strip_end) begin
         pos_in = POS_FIRST;
      end else begin
         case (pos_base)
            POS_FIRST:  pos_in = POS_SECOND;
            POS_SECOND: pos_in = POS_EVEN;
            POS_EVEN:   pos_in = POS_ODD;
            POS_ODD:    pos_in = POS_EVEN;
            default:    pos_in = POS_FIRST;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= POS_FIRST;
         prev0_ff       <= '0;
         prev1_ff       <= '0;
         tot_r_ff       <= '0;
         tot_g_ff       <= '0;
         tot_b_ff       <= '0;
         tot_all_ff     <= '0;
         best_energy_ff <= '0;
         best_area_ff   <= '0;
         best_color_ff  <= '0;
         best_c0_ff     <= '0;
         best_c1_ff     <= '0;
         best_c2_ff     <= '0;
      end else if (s1_adv) begin
         pos_ff         <= pos_in;
         prev0_ff       <= prev1_ff;
         prev1_ff       <= cur;
         tot_r_ff       <= tot_r_in;
         tot_g_ff       <= tot_g_in;
         tot_b_ff       <= tot_b_in;
         tot_all_ff     <= tot_all_in;
         best_energy_ff <= best_energy_in;
         best_c0_ff     <= best_c0_in;
         best_c1_ff     <= best_c1_in;
         best_c2_ff     <= best_c2_in;
         if (better) begin
            best_area_ff  <= s1_ff.patch_area;
            best_color_ff <= s1_ff.patch_color;
         end
      end
   end

   // strip-end snapshot, taken from the updated state
   assign snap_load = s1_adv && s1_ff.strip_end;
   always_comb begin
      snap.corners[0]  = to_corner(best_c0_in);
      snap.corners[1]  = to_corner(best_c1_in);
      snap.corners[2]  = to_corner(best_c2_in);
      snap.best_energy = best_energy_in;
      snap.best_area   = better ? s1_ff.patch_area : best_area_ff;
      snap.best_color  = better ? s1_ff.patch_color : best_color_ff;
      snap.total_red   = OUT_TOTAL_BITS'(tot_r_in);
      snap.total_green = OUT_TOTAL_BITS'(tot_g_in);
      snap.total_blue  = OUT_TOTAL_BITS'(tot_b_in);
      snap.total_all   = OUT_TOTAL_BITS'(tot_all_in);
   end

   sbps_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (snap_load),
      .snap     (snap),
      .status   (emit_st),
      .rsp_chan (rsp_chan)
   );

   // a snapshot never overwrites results still waiting
   a_snap_free: assert property (@(posedge clock) disable iff (reset)
      snap_load |-> (!emit_st.busy || emit_st.last_take))
      else $error("snapshot loaded during a result burst");

   // best energy only grows within a scene
   a_best_grows: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !s1_ff.scene_begin) |=> (best_energy_ff >= $past(best_energy_ff)))
      else $error("best energy decreased without scene begin");

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import sbps_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int RSP_HOLD_CYCLES = 80;
   localparam int MAX_STRIPS      = 2;
   localparam int MAX_STRIP_LEN   = 10;

   logic clock;
   logic reset;

   sbps_req_if req_chan ();
   sbps_rsp_if rsp_chan ();

   strip_brightest_patch_select u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Idling controls, changed per phase
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit rsp_hold_req  = 1'b0;
   int hold_left     = 0;

   // Bookkeeping
   int fail_count   = 0;
   int n_sent       = 0;
   int n_checked    = 0;
   int results_due  = 0;
   int quiet_cycles = 0;

   // Predictor state: strip position, last two vertices, totals, best patch
   vpos_type            strip_pos;
   corner_type          prior_vert [2];
   logic [47:0]         chan_total [3];
   logic [47:0]         all_total;
   logic [33:0]         best_e;
   logic [15:0]         best_a;
   logic [23:0]         best_c;
   corner_type          best_corner [3];

   // Results still owed by the block, oldest first
   rsp_type corner_queue [$];

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Saturating add into a 48-bit total
   function automatic logic [47:0] sat_total(input logic [47:0] acc, input logic [33:0] add);
      logic [48:0] sum;
      sum = {1'b0, acc} + 49'(add);
      return sum[48] ? {48{1'b1}} : sum[47:0];
   endfunction

   // Predict the effect of one accepted vertex request
   task automatic track_brightest(input req_type v);
      corner_type  cur;
      logic [15:0] rad [3];
      logic [31:0] prod;
      logic [33:0] energy;
      logic [1:0]  near_i;
      logic [1:0]  far_i;
      rsp_type     r;
      cur = '{x: v.vert_x, y: v.vert_y, z: v.vert_z};
      rad = '{v.unshot_red, v.unshot_green, v.unshot_blue};
      if (v.scene_begin) begin
         foreach (chan_total[c]) chan_total[c] = '0;
         all_total = '0;
         best_e    = '0;
      end
      if (v.strip_begin) strip_pos = POS_FIRST;

      // triangle closed from the third vertex on
      if (strip_pos == POS_EVEN || strip_pos == POS_ODD) begin
         energy = '0;
         for (int c = 0; c < 3; c++) begin
            prod = 32'(rad[c]) * 32'(v.patch_area);
            chan_total[c] = sat_total(chan_total[c], 34'(prod));
            energy += 34'(prod);
         end
         all_total = sat_total(all_total, energy);
         if (energy > best_e) begin
            // odd triangles swap corners 1 and 2 to keep winding
            near_i = (strip_pos == POS_EVEN) ? CORNER_MID : CORNER_LAST;
            far_i  = (strip_pos == POS_EVEN) ? CORNER_LAST : CORNER_MID;
            best_e = energy;
            best_a = v.patch_area;
            best_c = v.patch_color;
            best_corner[CORNER_FIRST] = prior_vert[0];
            best_corner[near_i]       = prior_vert[1];
            best_corner[far_i]        = cur;
         end
         strip_pos = (strip_pos == POS_EVEN) ? POS_ODD : POS_EVEN;
      end else begin
         strip_pos = (strip_pos == POS_FIRST) ? POS_SECOND : POS_EVEN;
      end
      prior_vert[0] = prior_vert[1];
      prior_vert[1] = cur;

      // strip end: one result per recorded corner
      if (v.strip_end) begin
         for (int k = 0; k < 3; k++) begin
            r.corner       = k[1:0];
            r.corner_x     = best_corner[k].x;
            r.corner_y     = best_corner[k].y;
            r.corner_z     = best_corner[k].z;
            r.best_energy  = best_e;
            r.best_area    = best_a;
            r.best_color   = best_c;
            r.total_red    = chan_total[0];
            r.total_green  = chan_total[1];
            r.total_blue   = chan_total[2];
            r.total_all    = all_total;
            r.final_corner = (k[1:0] == CORNER_LAST);
            corner_queue.push_back(r);
         end
         results_due += 3;
         strip_pos = POS_FIRST;
      end
   endtask

   function automatic void check_field(input string name, input logic [47:0] want,
                                       input logic [47:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // Result checker
   initial begin
      rsp_type want;
      rsp_type got;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.data;
            if (corner_queue.size() == 0) begin
               $error("result with no request waiting for it, corner %0d", got.corner);
               fail_count++;
            end else begin
               want = corner_queue.pop_front();
               results_due--;
               n_checked++;
               check_field("corner",       48'(want.corner),       48'(got.corner));
               check_field("corner_x",     48'(want.corner_x),     48'(got.corner_x));
               check_field("corner_y",     48'(want.corner_y),     48'(got.corner_y));
               check_field("corner_z",     48'(want.corner_z),     48'(got.corner_z));
               check_field("best_energy",  48'(want.best_energy),  48'(got.best_energy));
               check_field("best_area",    48'(want.best_area),    48'(got.best_area));
               check_field("best_color",   48'(want.best_color),   48'(got.best_color));
               check_field("total_red",    want.total_red,         got.total_red);
               check_field("total_green",  want.total_green,       got.total_green);
               check_field("total_blue",   want.total_blue,        got.total_blue);
               check_field("total_all",    want.total_all,         got.total_all);
               check_field("final_corner", 48'(want.final_corner), 48'(got.final_corner));
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold on request
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            hold_left    = RSP_HOLD_CYCLES;
            rsp_hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: cycles in a row with no handshake on either side
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   // Send one vertex request; called at a falling edge, returns at one
   task automatic send_vertex(input req_type v);
      req_chan.data  <= v;
      req_chan.valid <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      track_brightest(v);
      n_sent++;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Stop offering and wait for every owed result
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (results_due != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type vertex(input logic [15:0] x, y, z, r, g, b, area,
                                      input logic [23:0] color,
                                      input logic strip_b, strip_e, scene_b);
      req_type v;
      v.vert_x       = x;
      v.vert_y       = y;
      v.vert_z       = z;
      v.unshot_red   = r;
      v.unshot_green = g;
      v.unshot_blue  = b;
      v.patch_area   = area;
      v.patch_color  = color;
      v.strip_begin  = strip_b;
      v.strip_end    = strip_e;
      v.scene_begin  = scene_b;
      return v;
   endfunction

   // Random vertex, flags clear; radiance and area lean toward extremes now and then
   function automatic req_type random_vertex();
      req_type v;
      v = '0;
      v.vert_x       = 16'($urandom);
      v.vert_y       = 16'($urandom);
      v.vert_z       = 16'($urandom);
      v.unshot_red   = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
      v.unshot_green = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
      v.unshot_blue  = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
      case ($urandom_range(9))
         0:       v.patch_area = 16'h0000;
         1:       v.patch_area = 16'hFFFF;
         default: v.patch_area = 16'($urandom);
      endcase
      v.patch_color  = 24'($urandom);
      return v;
   endfunction

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Strips too short to close a triangle; patch fields there are ignored
   task automatic test_short_strips();
      send_vertex(vertex(16'h0001, 16'h0002, 16'h0003, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 24'hABCDEF, 1'b1, 1'b1, 1'b0));
      send_vertex(vertex(16'h1234, 16'h5678, 16'h9ABC, 16'h00FF, 16'hFF00, 16'h0F0F,
                         16'h8000, 24'h123456, 1'b1, 1'b0, 1'b0));
      send_vertex(vertex(16'hDEF0, 16'h0FED, 16'hCBA9, 16'hFFFF, 16'h0001, 16'h8000,
                         16'hFFFF, 24'hFEDCBA, 1'b0, 1'b1, 1'b0));
      drain();
   endtask

   // Even and odd winding, extreme values, a tie that must not replace,
   // then a strip with no begin flag and a zero-area patch
   task automatic test_winding_and_ties();
      send_vertex(vertex(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0, 1'b1));
      send_vertex(vertex(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b0));
      send_vertex(vertex(16'h0100, 16'hFF00, 16'h0080, 16'h0001, 16'h0002, 16'h0003,
                         16'h0001, 24'h000001, 1'b0, 1'b0, 1'b0));
      send_vertex(vertex(16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b0));
      send_vertex(vertex(16'h0000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 24'h000000, 1'b0, 1'b1, 1'b0));
      send_vertex(vertex(16'h1111, 16'h2222, 16'h3333, 16'h0000, 16'h0000, 16'h0000,
                         16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0));
      send_vertex(vertex(16'h4444, 16'h5555, 16'h6666, 16'h0000, 16'h0000, 16'h0000,
                         16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0));
      send_vertex(vertex(16'h7777, 16'h8888, 16'h9999, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'h0000, 24'h5A5A5A, 1'b0, 1'b1, 1'b0));
      drain();
   endtask

   // Strip restart in mid-strip, scene start in mid-strip, scene start alone
   task automatic test_restart_and_scene();
      send_vertex(vertex(16'h0A00, 16'h0B00, 16'h0C00, 16'h0000, 16'h0000, 16'h0000,
                         16'h0000, 24'h000000, 1'b1, 1'b0, 1'b0));
      send_vertex(vertex(16'h0D00, 16'h0E00, 16'h0F00, 16'h0000, 16'h0000, 16'h0000,
                         16'h0000, 24'h000000, 1'b0, 1'b0, 1'b0));
      send_vertex(vertex(16'hF000, 16'hE000, 16'hD000, 16'h0010, 16'h0010, 16'h0010,
                         16'h0100, 24'h0F0F0F, 1'b0, 1'b0, 1'b0));
      send_vertex(vertex(16'h0101, 16'h0202, 16'h0303, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 24'hF0F0F0, 1'b1, 1'b0, 1'b0));
      send_vertex(vertex(16'h0404, 16'h0505, 16'h0606, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 24'hF0F0F0, 1'b0, 1'b0, 1'b0));
      send_vertex(vertex(16'h0707, 16'h0808, 16'h0909, 16'h0001, 16'h0000, 16'h0000,
                         16'h0001, 24'h123456, 1'b0, 1'b1, 1'b1));
      send_vertex(vertex(16'hAAAA, 16'h5555, 16'hCCCC, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1));
      drain();
   endtask

   // Mostly well-formed strips with random content, some broken sequences
   task automatic run_random_strips(input int item_count);
      int      sent;
      int      len;
      bit      well_formed;
      req_type v;
      sent = 0;
      while (sent < item_count) begin
         well_formed = ($urandom_range(99) < 80);
         len = well_formed ? $urandom_range(1, 12) : $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            v = random_vertex();
            if (well_formed) begin
               v.strip_begin = (i == 0);
               v.strip_end   = (i == len - 1);
               v.scene_begin = (i == 0) && ($urandom_range(99) < 15);
            end else begin
               v.strip_begin = ($urandom_range(99) < 25);
               v.strip_end   = ($urandom_range(99) < 20);
               v.scene_begin = ($urandom_range(99) < 10);
            end
            send_vertex(v);
            sent++;
         end
      end
   endtask

   task automatic test_random_phases();
      set_idling(0, 0);
      run_random_strips(70);
      drain();
      set_idling(53, 0);
      run_random_strips(70);
      drain();
      set_idling(0, 53);
      run_random_strips(70);
      drain();
      set_idling(15, 15);
      run_random_strips(70);
      drain();
   endtask

   // Long receiver hold while three-vertex strips keep coming
   task automatic test_result_backpressure();
      req_type v;
      set_idling(0, 0);
      rsp_hold_req = 1'b1;
      for (int s = 0; s < 10; s++) begin
         for (int i = 0; i < 3; i++) begin
            v = random_vertex();
            v.strip_begin = (i == 0);
            v.strip_end   = (i == 2);
            send_vertex(v);
         end
      end
      drain();
   endtask

   // Strips of maximum-energy triangles, largest products into every total
   task automatic test_max_energy();
      req_type v;
      set_idling(0, 0);
      for (int s = 0; s < MAX_STRIPS; s++) begin
         for (int i = 0; i < MAX_STRIP_LEN; i++) begin
            v = random_vertex();
            v.unshot_red   = 16'hFFFF;
            v.unshot_green = 16'hFFFF;
            v.unshot_blue  = 16'hFFFF;
            v.patch_area   = 16'hFFFF;
            v.strip_begin  = (i == 0);
            v.strip_end    = (i == MAX_STRIP_LEN - 1);
            v.scene_begin  = (s == 0) && (i == 0);
            send_vertex(v);
         end
      end
      drain();
   endtask

   // Main sequence
   initial begin
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      strip_pos      = POS_FIRST;
      prior_vert     = '{default: '0};
      chan_total     = '{default: '0};
      all_total      = '0;
      best_e         = '0;
      best_a         = '0;
      best_c         = '0;
      best_corner    = '{default: '0};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_short_strips();
      test_winding_and_ties();
      test_restart_and_scene();
      test_random_phases();
      test_result_backpressure();
      test_max_energy();

      repeat (10) @(posedge clock);
      $display("Sent %0d vertices; checked %0d corner results.", n_sent, n_checked);
      $display("Covered short strips, winding, ties, restarts, idling phases, a long");
      $display("result stall and strips of maximum-energy triangles.");
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
